>>> rtl/core/raw_pkg.sv
// Package for the RADIUS attribute walker: record kinds, status codes and
// the result record type shared by the front, the queue and the back.
// No dependencies.
package raw_pkg;
	localparam int MaxFrameBytes = 4096;
	localparam logic [31:0] VendorIdReset = 32'd2011;
	localparam logic [15:0] HdrLen = 16'd20;
	localparam logic [7:0] VsaType = 8'd26;
	localparam int QueueDepth = 4;

	localparam logic [1:0] KIND_STD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_BADHDR = 2'd2;
	localparam logic [1:0] ST_MALFORM = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  code;
		logic [7:0]  ident;
		logic [7:0]  atype;
		logic [7:0]  vlen;
		logic [63:0] head;
		logic [15:0] tail;
		logic [1:0]  status;
	} rec_t;

	// Two records may come from one byte: an attribute and the summary.
	typedef struct packed {
		logic n_rec;
		logic two;
		rec_t r0;
		rec_t r1;
	} pair_t;
endpackage

>>> rtl/core/raw_front.sv
// Front of the attribute walker: per-byte header and attribute state machine.
// Produces zero, one or two result records per accepted byte. Uses raw_pkg.
module raw_front #(
	parameter int MAX_FRAME_BYTES = raw_pkg::MaxFrameBytes
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic [12:0]         frame_length,
	input  logic                first_of_frame,
	input  logic [31:0]         own_vendor,
	output raw_pkg::pair_t      pair
);
	import raw_pkg::*;

	localparam logic [16:0] MaxFb = 17'(MAX_FRAME_BYTES);

	logic [16:0] pos_q, fb_q;
	logic [15:0] mlen_q;
	logic [7:0]  code_q, ident_q, atype_q, alen_q, acnt_q;
	logic [1:0]  status_q;
	logic [63:0] vsh_q;
	logic [15:0] tsh_q;
	logic [31:0] vnd_q;
	logic [7:0]  stype_q, slen_q, scnt_q;
	logic        sact_q;

	// Next-state copies.
	logic [16:0] pos_d, fb_d, p;
	logic [15:0] mlen_d;
	logic [7:0]  code_d, ident_d, atype_d, alen_d, acnt_d;
	logic [1:0]  status_d;
	logic [63:0] vsh_d;
	logic [15:0] tsh_d;
	logic [31:0] vnd_d;
	logic [7:0]  stype_d, slen_d, scnt_d;
	logic        sact_d;
	logic        e_attr, e_fin;
	rec_t        ra;
	logic [7:0]  v, vidx;
	logic [8:0]  remaining;
	logic        place;

	always_comb begin
		pos_d = pos_q; fb_d = fb_q; mlen_d = mlen_q; code_d = code_q;
		ident_d = ident_q; atype_d = atype_q; alen_d = alen_q; acnt_d = acnt_q;
		status_d = status_q; vsh_d = vsh_q; tsh_d = tsh_q; vnd_d = vnd_q;
		stype_d = stype_q; slen_d = slen_q; scnt_d = scnt_q; sact_d = sact_q;
		e_attr = 1'b0; e_fin = 1'b0; place = 1'b0; vidx = '0;
		ra = '0;
		v = acnt_q - 8'd2;
		remaining = {1'b0, alen_q} - 9'd2 - {1'b0, v};
		p = pos_q;
		if (first_of_frame) begin
			pos_d = '0; fb_d = '0; mlen_d = '0; code_d = '0; ident_d = '0;
			status_d = ST_OK; atype_d = '0; alen_d = '0; acnt_d = '0;
			vsh_d = '0; tsh_d = '0; vnd_d = '0; stype_d = '0; slen_d = '0;
			scnt_d = '0; sact_d = 1'b0;
			p = '0;
			if (frame_length < 13'(HdrLen)) begin
				status_d = ST_SHORT;
				e_fin = 1'b1;
			end else begin
				fb_d = (17'(frame_length) > MaxFb) ? MaxFb : 17'(frame_length);
			end
		end
		if (!e_fin && p < fb_d) begin
			if (p == 17'd0) code_d = data_byte;
			else if (p == 17'd1) ident_d = data_byte;
			else if (p == 17'd2) mlen_d = {data_byte, 8'd0};
			else if (p == 17'd3) begin
				mlen_d = {mlen_q[15:8], data_byte};
				if (mlen_d < HdrLen || 17'(mlen_d) > fb_d) begin
					status_d = ST_BADHDR;
					e_fin = 1'b1;
				end
			end else if (p >= 17'(HdrLen) && p < 17'(mlen_q) && status_q == ST_OK) begin
				if (acnt_q == 8'd0) begin
					if (!(p + 17'd2 > 17'(mlen_q))) begin
						atype_d = data_byte; acnt_d = 8'd1; vsh_d = '0; tsh_d = '0;
					end
				end else if (acnt_q == 8'd1) begin
					alen_d = data_byte;
					if (data_byte < 8'd2 || (p - 17'd1 + 17'(data_byte)) > 17'(mlen_q)) begin
						status_d = ST_MALFORM;
					end else begin
						vnd_d = '0; sact_d = 1'b0; scnt_d = '0;
						acnt_d = (data_byte == 8'd2) ? 8'd0 : 8'd2;
					end
				end else begin
					if (atype_q == VsaType) begin
						if (v < 8'd4) begin
							vnd_d = {vnd_q[23:0], data_byte};
							if (v == 8'd3) begin
								sact_d = (vnd_d == own_vendor);
								scnt_d = '0;
							end
						end else if (sact_q) begin
							if (scnt_q == 8'd0) begin
								if (remaining < 9'd2) sact_d = 1'b0;
								else begin
									stype_d = data_byte; scnt_d = 8'd1;
									vsh_d = '0; tsh_d = '0;
								end
							end else if (scnt_q == 8'd1) begin
								slen_d = data_byte;
								if (data_byte < 8'd2 || {1'b0, data_byte} > remaining + 9'd1)
									sact_d = 1'b0;
								else if (data_byte == 8'd2) begin
									e_attr = 1'b1;
									ra.kind = KIND_SUB; ra.atype = stype_q;
									scnt_d = '0;
								end else scnt_d = 8'd2;
							end else begin
								place = 1'b1; vidx = scnt_q - 8'd2;
								scnt_d = scnt_q + 8'd1;
								if (scnt_d == slen_q) begin
									e_attr = 1'b1; ra.kind = KIND_SUB; ra.atype = stype_q;
									ra.vlen = slen_q - 8'd2;
									scnt_d = '0;
								end
							end
						end
					end else begin
						place = 1'b1; vidx = v;
					end
					acnt_d = acnt_q + 8'd1;
					if (acnt_d == alen_q) begin
						if (atype_q != VsaType) begin
							e_attr = 1'b1; ra.kind = KIND_STD; ra.atype = atype_q;
							ra.vlen = alen_q - 8'd2;
						end
						acnt_d = '0;
					end
				end
			end
			if (place) begin
				if (vidx < 8'd8) vsh_d = vsh_q | ({56'd0, data_byte} << (7'd56 - {vidx[3:0], 3'd0}));
				else if (vidx == 8'd8) tsh_d = tsh_q | {data_byte, 8'd0};
				else if (vidx == 8'd9) tsh_d = tsh_q | {8'd0, data_byte};
			end
			ra.head = vsh_d; ra.tail = tsh_d;
			if (!e_fin) begin
				if (p + 17'd1 == fb_d) e_fin = 1'b1;
				else pos_d = p + 17'd1;
			end
		end
		if (e_fin) begin
			pos_d = '0; fb_d = '0;
		end
		ra.code = code_d; ra.ident = ident_d; ra.status = status_d;
		pair.r0 = ra;
		pair.r1 = '0;
		pair.r1.kind = KIND_END; pair.r1.code = code_d; pair.r1.ident = ident_d;
		pair.r1.status = status_d;
		if (!e_attr) pair.r0 = pair.r1;
		pair.n_rec = e_attr | e_fin;
		pair.two = e_attr & e_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; fb_q <= '0; mlen_q <= '0; code_q <= '0; ident_q <= '0;
			atype_q <= '0; alen_q <= '0; acnt_q <= '0; status_q <= '0; vsh_q <= '0;
			tsh_q <= '0; vnd_q <= '0; stype_q <= '0; slen_q <= '0; scnt_q <= '0;
			sact_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_d; fb_q <= fb_d; mlen_q <= mlen_d; code_q <= code_d;
			ident_q <= ident_d; atype_q <= atype_d; alen_q <= alen_d; acnt_q <= acnt_d;
			status_q <= status_d; vsh_q <= vsh_d; tsh_q <= tsh_d; vnd_q <= vnd_d;
			stype_q <= stype_d; slen_q <= slen_d; scnt_q <= scnt_d; sact_q <= sact_d;
		end
	end
endmodule

>>> rtl/core/raw_queue.sv
// Record queue between the walker front and the output stage.
// Takes up to two records per cycle, hands out one when rd_en takes it. Uses raw_pkg.
module raw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  raw_pkg::pair_t  wr,
	input  logic            wr_en,
	output logic            room,
	output logic            rd_valid,
	output raw_pkg::rec_t   rd_data,
	input  logic            rd_en
);
	import raw_pkg::*;

	localparam int Aw = $clog2(QueueDepth);

	rec_t mem_q [QueueDepth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0]   cnt_q;
	logic [1:0]    n_in;
	logic          pop;

	assign n_in = (wr_en && wr.n_rec) ? (wr.two ? 2'd2 : 2'd1) : 2'd0;
	assign pop = rd_en && rd_valid;
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	// Room for two more, so a byte can always be taken.
	assign room = cnt_q <= (Aw+1)'(QueueDepth - 2);

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) mem_q[wp_q] <= wr.r0;
		if (n_in == 2'd2) mem_q[wp_q + Aw'(1)] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + Aw'(n_in);
			if (pop) rp_q <= rp_q + Aw'(1);
			cnt_q <= cnt_q + (Aw+1)'(n_in) - (Aw+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (Aw+1)'(QueueDepth))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) !room |-> cnt_q != '0)
		else $error("queue full while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr.two) |-> wr.n_rec) else $error("two records without any");
endmodule

>>> rtl/core/radius_attribute_walker_core.sv
// RADIUS attribute walker, top level: front walker, record queue, output ports.
// Each record is registered in the queue and leaves it behind any older records.
// Throughput: one byte per cycle while the queue has room; a byte causing two
// records writes both into the four-entry queue.
// Reset: asynchronous, clears all frame state; the vendor register returns to 2011.
module radius_attribute_walker_core #(
	parameter int MAX_FRAME_BYTES = raw_pkg::MaxFrameBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [12:0] frame_length,
	input  logic        first_of_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [7:0]  message_code,
	output logic [7:0]  message_ident,
	output logic        request_msg,
	output logic [7:0]  attribute_type,
	output logic [7:0]  value_length,
	output logic [63:0] value_head,
	output logic [15:0] value_tail,
	output logic [1:0]  frame_status,
	output logic        last_of_frame
);
	import raw_pkg::*;

	logic [31:0] vendor_q;
	pair_t pair;
	rec_t  r;
	logic  step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vendor_q <= VendorIdReset;
		else if (cfg_we) vendor_q <= cfg_wdata;
	end

	assign step = in_valid && in_ready;

	raw_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
		.clk, .arst_n, .step, .data_byte, .frame_length, .first_of_frame,
		.own_vendor(vendor_q), .pair
	);

	raw_queue u_queue (
		.clk, .arst_n, .wr(pair), .wr_en(step), .room(in_ready),
		.rd_valid(out_valid), .rd_data(r), .rd_en(out_ready)
	);

	assign record_kind = r.kind;
	assign message_code = r.code;
	assign message_ident = r.ident;
	assign request_msg = (r.code == 8'd1) || (r.code == 8'd4) || (r.code == 8'd10);
	assign attribute_type = r.atype;
	assign value_length = r.vlen;
	assign value_head = r.head;
	assign value_tail = r.tail;
	assign frame_status = r.status;
	assign last_of_frame = r.kind == KIND_END;
endmodule
